@@ design/dv128_pkg.sv @@
// ----------------------------------------------------------------------------
// dv128_pkg
// shared types and constants for the 128 by 64 bit pipelined divider
// ----------------------------------------------------------------------------
package dv128_pkg;

  localparam int WORD_W  = 64;
  localparam int DIVD_W  = 2 * WORD_W;
  localparam int N_STEPS = DIVD_W;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // one pipeline stage: the dividend shifts left, quotient bits enter at the bottom
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              dz;
    logic [WORD_W-1:0] rem;
    logic [DIVD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } dv128_stage_t;

endpackage

@@ design/dv128_if.sv @@
// ----------------------------------------------------------------------------
// dv128 channel interfaces
// valid/ready channels for operand items and quotient items
// ----------------------------------------------------------------------------
interface dv128_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] dividend_high;
  logic [63:0] dividend_low;
  logic [63:0] divisor;

  modport source (output valid, opcode, dividend_high, dividend_low, divisor, input ready);
  modport sink   (input valid, opcode, dividend_high, dividend_low, divisor, output ready);
endinterface

interface dv128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] quotient;
  logic        divide_by_zero;

  modport source (output valid, quotient, divide_by_zero, input ready);
  modport sink   (input valid, quotient, divide_by_zero, output ready);
endinterface

@@ design/dv128_prep.sv @@
// ----------------------------------------------------------------------------
// dv128_prep
// operand stage: magnitudes in signed mode, sign of the result, zero divisor
// ----------------------------------------------------------------------------
module dv128_prep import dv128_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic              opcode,
  input  logic [WORD_W-1:0] dividend_high,
  input  logic [WORD_W-1:0] dividend_low,
  input  logic [WORD_W-1:0] divisor,
  output dv128_stage_t      stg_o
);

  dv128_stage_t      stg_r;
  dv128_stage_t      stg_nxt;
  logic              num_neg;
  logic              den_neg;
  logic [DIVD_W-1:0] num_raw;

  always_comb begin
    num_raw  = {dividend_high, dividend_low};
    num_neg  = (opcode == OP_SIGNED) && dividend_high[WORD_W-1];
    den_neg  = (opcode == OP_SIGNED) && divisor[WORD_W-1];
    stg_nxt.valid = in_valid;
    stg_nxt.neg   = num_neg ^ den_neg;
    stg_nxt.dz    = (divisor == '0);
    stg_nxt.rem   = '0;
    stg_nxt.num   = num_neg ? (~num_raw + {{(DIVD_W-1){1'b0}}, 1'b1}) : num_raw;
    stg_nxt.den   = den_neg ? (~divisor + {{(WORD_W-1){1'b0}}, 1'b1}) : divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_o = stg_r;

endmodule

@@ design/dv128_step.sv @@
// ----------------------------------------------------------------------------
// dv128_step
// one restoring division step: shift in a dividend bit, compare and subtract
// ----------------------------------------------------------------------------
module dv128_step import dv128_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  dv128_stage_t stg_i,
  output dv128_stage_t stg_o
);

  dv128_stage_t    stg_r;
  dv128_stage_t    stg_nxt;
  logic [WORD_W:0] trial;
  logic [WORD_W:0] diff;
  logic            ge;

  always_comb begin
    trial   = {stg_i.rem, stg_i.num[DIVD_W-1]};
    diff    = trial - {1'b0, stg_i.den};
    ge      = !diff[WORD_W];
    stg_nxt = stg_i;
    stg_nxt.rem = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    stg_nxt.num = {stg_i.num[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_o = stg_r;

endmodule

@@ design/dv128_post.sv @@
// ----------------------------------------------------------------------------
// dv128_post
// result stage: sign fix-up of the quotient, zero divisor result, output register
// ----------------------------------------------------------------------------
module dv128_post import dv128_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  dv128_stage_t      stg_i,
  output logic              out_valid,
  output logic [WORD_W-1:0] quotient,
  output logic              divide_by_zero
);

  logic              valid_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] quo_nxt;
  logic              dz_r;
  logic [WORD_W-1:0] quo_raw;

  always_comb begin
    quo_raw = stg_i.num[WORD_W-1:0];
    if (stg_i.dz) begin
      quo_nxt = '1;
    end else if (stg_i.neg) begin
      quo_nxt = ~quo_raw + {{(WORD_W-1){1'b0}}, 1'b1};
    end else begin
      quo_nxt = quo_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stg_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      dz_r  <= stg_i.dz;
    end
  end

  assign out_valid      = valid_r;
  assign quotient       = quo_r;
  assign divide_by_zero = dz_r;

endmodule

@@ design/divide_128_by_64.sv @@
// ----------------------------------------------------------------------------
// divide_128_by_64
// pipelined 128 by 64 bit integer divider, unsigned or signed, quotient mod 2^64
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the output stalls, through one
// operand stage, 128 restoring division stages that each retire one dividend
// bit with a 65-bit subtract, and one output stage. When the result at the
// output is not taken the whole pipeline holds and the input is not ready;
// while the output register is empty or its result is taken every stage
// advances, and empty slots travel along without closing up. A zero divisor
// returns all ones with divide_by_zero set. No reset sweep is needed.
// ----------------------------------------------------------------------------
module divide_128_by_64 import dv128_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  dv128_in_if.sink    in_chan,
  dv128_out_if.source out_chan
);

  dv128_stage_t stg [0:N_STEPS];
  logic         en;

  assign en            = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  dv128_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_chan.valid),
    .opcode        (in_chan.opcode),
    .dividend_high (in_chan.dividend_high),
    .dividend_low  (in_chan.dividend_low),
    .divisor       (in_chan.divisor),
    .stg_o         (stg[0])
  );

  for (genvar i = 0; i < N_STEPS; i++) begin : g_step
    dv128_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (stg[i]),
      .stg_o (stg[i+1])
    );
  end

  dv128_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .stg_i          (stg[N_STEPS]),
    .out_valid      (out_chan.valid),
    .quotient       (out_chan.quotient),
    .divide_by_zero (out_chan.divide_by_zero)
  );

endmodule

@@ design/dv128_checker.sv @@
// ----------------------------------------------------------------------------
// dv128_checker
// port-level checks on the divider, bound to the top level
// ----------------------------------------------------------------------------
module dv128_checker import dv128_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] quotient,
  input logic              divide_by_zero
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(divide_by_zero))
    else $error("result changed while stalled");

  // zero divisor gives all ones
  a_dz_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_by_zero |-> quotient == '1)
    else $error("zero divisor result not all ones");

  // input blocked exactly while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind divide_128_by_64 dv128_checker u_dv128_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .quotient       (out_chan.quotient),
  .divide_by_zero (out_chan.divide_by_zero)
);
